### rtl/cas_pkg.sv
`timescale 1ns / 1ps
package cas_pkg;

  localparam int DEPTH_BITS_DEF  = 8;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int ARG_BITS_DEF    = 8;

  // fixed widths of the result fields on the port
  localparam int OFFSET_W = 16;
  localparam int ARG_W    = 8;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    KIND_ARG  = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_WAIT_OPEN   = 3'd0,
    PH_AFTER_OPEN  = 3'd1,
    PH_SCAN        = 3'd2,
    PH_AFTER_COMMA = 3'd3,
    PH_DONE        = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       span_end;
  } in_item_t;

  typedef struct packed {
    kind_t               result_kind;
    logic [OFFSET_W-1:0] arg_offset;
    logic [ARG_W-1:0]    arg_number;
    logic                run_last;
  } res_t;

  typedef struct packed {
    res_t       first;
    res_t       second;
    logic [1:0] count;
  } res_pair_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL);
  endfunction

endpackage

### rtl/cas_if.sv
`timescale 1ns / 1ps
interface cas_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       span_end;

  modport source (output valid, output text_byte, output span_end, input ready);
  modport sink (input valid, input text_byte, input span_end, output ready);
endinterface

interface cas_result_if import cas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [OFFSET_W-1:0] arg_offset;
  logic [ARG_W-1:0]    arg_number;
  logic                run_last;

  modport source (output valid, output result_kind, output arg_offset,
                  output arg_number, output run_last, input ready);
  modport sink (input valid, input result_kind, input arg_offset,
                input arg_number, input run_last, output ready);
endinterface

### rtl/cas_in_reg.sv
`timescale 1ns / 1ps
module cas_in_reg import cas_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  cas_text_if.sink text,
  input  logic     take,
  output logic     valid,
  output in_item_t item
);

  assign text.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text.ready) begin
      valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item.text_byte <= text.text_byte;
      item.span_end  <= text.span_end;
    end
  end

endmodule

### rtl/cas_scan.sv
`timescale 1ns / 1ps
module cas_scan import cas_pkg::*; #(
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int ARG_BITS    = ARG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid,
  input  in_item_t  item,
  input  logic      slot_free,
  output logic      take,
  output logic      load,
  output res_pair_t pair
);

  phase_t                 phase, phase_next;
  logic [DEPTH_BITS-1:0]  paren_depth, paren_depth_next;
  logic [DEPTH_BITS-1:0]  bracket_depth, bracket_depth_next;
  logic [DEPTH_BITS-1:0]  brace_depth, brace_depth_next;
  logic                   in_string, in_string_next;
  logic                   escape_pending, escape_pending_next;
  logic                   in_line_comment, in_line_comment_next;
  logic                   slash_pending, slash_pending_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [ARG_BITS-1:0]    arg_count, arg_count_next;

  always_comb begin
    logic [7:0]                      b;
    logic                            last;
    status_t                         st;
    logic                            scan_en;
    logic                            arg_emit;
    logic [DEPTH_BITS-1:0]           pd_base;
    logic [OFFSET_BITS+OFFSET_W-1:0] pos_ext;
    logic [ARG_BITS+ARG_W-1:0]       num_ext;
    res_t                            arg_res;
    res_t                            st_res;

    b        = item.text_byte;
    last     = item.span_end;
    st       = ST_NONE;
    scan_en  = 1'b0;
    arg_emit = 1'b0;
    pd_base  = paren_depth;

    phase_next           = phase;
    paren_depth_next     = paren_depth;
    bracket_depth_next   = bracket_depth;
    brace_depth_next     = brace_depth;
    in_string_next       = in_string;
    escape_pending_next  = escape_pending;
    in_line_comment_next = in_line_comment;
    slash_pending_next   = slash_pending;
    arg_count_next       = arg_count;
    byte_position_next   = byte_position + OFFSET_BITS'(1);

    unique case (phase)
      PH_WAIT_OPEN: begin
        if (b == CH_LPAREN) begin
          phase_next = PH_AFTER_OPEN;
        end else if (!is_space(b)) begin
          st = ST_FAIL;
        end
      end
      PH_AFTER_OPEN, PH_AFTER_COMMA: begin
        if (is_space(b)) begin
          st = ST_NONE;
        end else if (b == CH_RPAREN) begin
          st = (phase == PH_AFTER_OPEN) ? ST_OK : ST_FAIL;
        end else if (&arg_count) begin
          st = ST_FAIL;
        end else begin
          if (phase == PH_AFTER_OPEN) begin
            pd_base = DEPTH_BITS'(1);
          end
          arg_emit       = 1'b1;
          arg_count_next = arg_count + ARG_BITS'(1);
          phase_next     = PH_SCAN;
          scan_en        = 1'b1;
        end
      end
      PH_SCAN: scan_en = 1'b1;
      PH_DONE: scan_en = 1'b0;
      default: scan_en = 1'b0;
    endcase

    paren_depth_next = pd_base;

    if (scan_en) begin
      if (in_line_comment) begin
        if (b == CH_NL) begin
          in_line_comment_next = 1'b0;
        end
      end else if (in_string) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (b == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (b == CH_QUOTE) begin
          in_string_next = 1'b0;
        end
      end else begin
        slash_pending_next = 1'b0;
        if (slash_pending && (b == CH_SLASH)) begin
          in_line_comment_next = 1'b1;
        end else if (b == CH_QUOTE) begin
          in_string_next = 1'b1;
        end else if (b == CH_SLASH) begin
          slash_pending_next = 1'b1;
        end else begin
          unique case (b)
            CH_LPAREN: begin
              if (&pd_base) st = ST_FAIL;
              else paren_depth_next = pd_base + DEPTH_BITS'(1);
            end
            CH_RPAREN: begin
              if (pd_base == '0) begin
                st = ST_FAIL;
              end else begin
                paren_depth_next = pd_base - DEPTH_BITS'(1);
                if (pd_base == DEPTH_BITS'(1)) st = ST_OK;
              end
            end
            CH_LBRACK: begin
              if (&bracket_depth) st = ST_FAIL;
              else bracket_depth_next = bracket_depth + DEPTH_BITS'(1);
            end
            CH_RBRACK: begin
              if (bracket_depth == '0) st = ST_FAIL;
              else bracket_depth_next = bracket_depth - DEPTH_BITS'(1);
            end
            CH_LBRACE: begin
              if (&brace_depth) st = ST_FAIL;
              else brace_depth_next = brace_depth + DEPTH_BITS'(1);
            end
            CH_RBRACE: begin
              if (brace_depth == '0) st = ST_FAIL;
              else brace_depth_next = brace_depth - DEPTH_BITS'(1);
            end
            CH_COMMA: begin
              // top-level separator only
              if ((pd_base == DEPTH_BITS'(1)) && (bracket_depth == '0) &&
                  (brace_depth == '0)) begin
                phase_next = PH_AFTER_COMMA;
              end
            end
            default: st = st;
          endcase
        end
      end
    end

    // span ran out before the call closed
    if ((st == ST_NONE) && last && (phase_next != PH_DONE)) begin
      st = ST_FAIL;
    end
    if (st != ST_NONE) begin
      phase_next = PH_DONE;
    end

    pos_ext = {{OFFSET_W{1'b0}}, byte_position};

    arg_res.result_kind = KIND_ARG;
    arg_res.arg_offset  = pos_ext[OFFSET_W-1:0];
    num_ext             = {{ARG_W{1'b0}}, arg_count};
    arg_res.arg_number  = num_ext[ARG_W-1:0];
    arg_res.run_last    = (st == ST_NONE);

    st_res.result_kind = (st == ST_OK) ? KIND_OK : KIND_FAIL;
    st_res.arg_offset  = pos_ext[OFFSET_W-1:0];
    num_ext            = {{ARG_W{1'b0}}, arg_count_next};
    st_res.arg_number  = num_ext[ARG_W-1:0];
    st_res.run_last    = 1'b1;

    pair.first  = arg_emit ? arg_res : st_res;
    pair.second = st_res;
    pair.count  = 2'(arg_emit) + 2'(st != ST_NONE);

    if (last) begin
      phase_next           = PH_WAIT_OPEN;
      paren_depth_next     = '0;
      bracket_depth_next   = '0;
      brace_depth_next     = '0;
      in_string_next       = 1'b0;
      escape_pending_next  = 1'b0;
      in_line_comment_next = 1'b0;
      slash_pending_next   = 1'b0;
      byte_position_next   = '0;
      arg_count_next       = '0;
    end
  end

  // bytes with no result never wait on the output side
  assign take = valid && ((pair.count == 2'd0) || slot_free);
  assign load = take && (pair.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT_OPEN;
      paren_depth     <= '0;
      bracket_depth   <= '0;
      brace_depth     <= '0;
      in_string       <= 1'b0;
      escape_pending  <= 1'b0;
      in_line_comment <= 1'b0;
      slash_pending   <= 1'b0;
      byte_position   <= '0;
      arg_count       <= '0;
    end else if (take) begin
      phase           <= phase_next;
      paren_depth     <= paren_depth_next;
      bracket_depth   <= bracket_depth_next;
      brace_depth     <= brace_depth_next;
      in_string       <= in_string_next;
      escape_pending  <= escape_pending_next;
      in_line_comment <= in_line_comment_next;
      slash_pending   <= slash_pending_next;
      byte_position   <= byte_position_next;
      arg_count       <= arg_count_next;
    end
  end

endmodule

### rtl/cas_out_reg.sv
`timescale 1ns / 1ps
module cas_out_reg import cas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  res_pair_t    pair,
  output logic         slot_free,
  cas_result_if.source result
);

  res_t       head;
  res_t       tail;
  logic [1:0] count;
  logic       pop;

  assign pop       = result.valid && result.ready;
  assign slot_free = (count == 2'd0) || ((count == 2'd1) && result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pair.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= pair.first;
      tail <= pair.second;
    end else if (pop && (count == 2'd2)) begin
      head <= tail;
    end
  end

  assign result.valid       = (count != 2'd0);
  assign result.result_kind = head.result_kind;
  assign result.arg_offset  = head.arg_offset;
  assign result.arg_number  = head.arg_number;
  assign result.run_last    = head.run_last;

endmodule

### rtl/call_argument_splitter_top.sv
`timescale 1ns / 1ps
// Splits the bytes of one call (from just after the callee name up to the byte
// flagged span_end) into top-level arguments, one byte per item on text. Each
// byte is registered, decoded against the nesting/string/comment state
// combinationally, and its results land in a two-entry output register, so a new
// byte is taken every cycle while the result port keeps up. A byte that yields
// an argument start plus a status fills both entries, and a following byte with
// results waits until one is taken; bytes without results pass regardless of result.ready.
// Between byte acceptance and its first result lie the input and output registers.
module call_argument_splitter_top import cas_pkg::*; #(
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int ARG_BITS    = ARG_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  cas_text_if.sink     text,
  cas_result_if.source result
);

  logic      in_valid;
  in_item_t  in_item;
  logic      take;
  logic      load;
  logic      slot_free;
  res_pair_t pair;

  cas_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .take  (take),
    .valid (in_valid),
    .item  (in_item)
  );

  cas_scan #(
    .DEPTH_BITS  (DEPTH_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .ARG_BITS    (ARG_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .valid     (in_valid),
    .item      (in_item),
    .slot_free (slot_free),
    .take      (take),
    .load      (load),
    .pair      (pair)
  );

  cas_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .pair      (pair),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule

### rtl/cas_checker.sv
`timescale 1ns / 1ps
module cas_checker import cas_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                text_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [1:0]          result_kind,
  input logic [OFFSET_W-1:0] arg_offset,
  input logic [ARG_W-1:0]    arg_number,
  input logic                run_last
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable({result_kind, arg_offset, arg_number, run_last}))
    else $error("result changed while stalled");

  // text only backs up behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> result_valid)
    else $error("text stalled with no result pending");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((result_kind == KIND_OK) || (result_kind == KIND_FAIL))
      |-> run_last)
    else $error("status item not marked last");

  // argument start followed in the same byte can only be a failure
  a_arg_then_fail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && (result_kind == KIND_ARG) && !run_last
      |=> result_valid && (result_kind == KIND_FAIL))
    else $error("second item of a byte is not a failure");

endmodule

bind call_argument_splitter_top cas_checker u_cas_checker (
  .clk          (clk),
  .rst          (rst),
  .text_ready   (text.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_kind  (result.result_kind),
  .arg_offset   (result.arg_offset),
  .arg_number   (result.arg_number),
  .run_last     (result.run_last)
);
